[rtl/ptts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_pkg
// Types and constants shared by the periodic task tick scheduler modules.
// ----------------------------------------------------------------------------
package ptts_pkg;

    localparam int MASK_W     = 4;
    localparam int OPCODE_W   = 2;
    localparam int TASK_IDX_W = 2;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_REGS   = 8;
    localparam int MAX_SLOTS  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY_BASE = 3'd4;

    localparam logic [CFG_W-1:0] INTERVAL_RESET [MAX_SLOTS] = '{
        16'd500, 16'd10000, 16'd1000, 16'd3000
    };
    localparam logic [CFG_W-1:0] FIRST_DELAY_RESET [MAX_SLOTS] = '{
        16'd500, 16'd500, 16'd1000, 16'd1000
    };

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK       = 2'd0,
        OP_DISPATCH   = 2'd1,
        OP_SET_ENABLE = 2'd2,
        OP_START      = 2'd3
    } op_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [TASK_IDX_W-1:0] task_index;
        logic                  enable_value;
        logic [MASK_W-1:0]     start_pending_mask;
    } ptts_in_t;

    typedef struct packed {
        logic [MASK_W-1:0] dispatched_mask;
        logic [MASK_W-1:0] pending_mask;
        logic [MASK_W-1:0] enable_mask;
    } ptts_out_t;

    // per-slot controls for one accepted word
    typedef struct packed {
        logic tick;
        logic dispatch;
        logic set_enable;
        logic start;
        logic enable_value;
        logic start_pending;
    } ptts_ctl_t;

endpackage
`default_nettype wire

[rtl/ptts_timer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_timer
// One task slot: countdown, pending flag and enable bit.
// ----------------------------------------------------------------------------
module ptts_timer
    import ptts_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ptts_ctl_t              ctl,
    input  wire logic [COUNT_WIDTH-1:0] interval,
    input  wire logic [COUNT_WIDTH-1:0] first_delay,
    output logic                        dispatched,
    output logic                        pending_next,
    output logic                        enabled_next
);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   pending_reg;
    logic                   enabled_reg;
    logic [COUNT_WIDTH-1:0] count_dec;

    assign count_dec = count_reg - COUNT_WIDTH'(1);

    always_comb begin
        count_next   = count_reg;
        pending_next = pending_reg;
        enabled_next = enabled_reg;
        dispatched   = 1'b0;
        if (ctl.tick && enabled_reg && (count_reg != '0)) begin
            if (count_dec == '0) begin
                count_next   = interval;
                pending_next = 1'b1;
            end else begin
                count_next = count_dec;
            end
        end
        if (ctl.dispatch && enabled_reg && pending_reg) begin
            dispatched   = 1'b1;
            pending_next = 1'b0;
        end
        if (ctl.set_enable) begin
            enabled_next = ctl.enable_value;
        end
        if (ctl.start) begin
            count_next   = first_delay;
            pending_next = ctl.start_pending;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
            enabled_reg <= 1'b1;
        end else begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
            enabled_reg <= enabled_next;
        end
    end

endmodule
`default_nettype wire

[rtl/periodic_task_tick_scheduler.sv]
// a result word is registered and valid in the cycle after its input word is accepted
// throughput: one input word per cycle while m_ready drains the single result register
// s_ready stays high while the result register is empty or being drained
// reset clears countdowns and pending flags, sets all enables and restores
// the interval and first-delay registers to their defaults
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Bank of periodic task timers driven by tick, dispatch, set-enable and start
// words, with a plain configuration write port.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler
    import ptts_pkg::*;
#(
    parameter int TASK_SLOTS  = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ptts_in_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ptts_out_t                 m_data
);

    logic [CFG_W-1:0] interval_reg    [TASK_SLOTS];
    logic [CFG_W-1:0] first_delay_reg [TASK_SLOTS];

    logic                  accept;
    logic [TASK_SLOTS-1:0] disp_vec, pend_vec, en_vec;
    ptts_out_t             result;
    logic                  m_valid_reg;
    ptts_out_t             m_data_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_slot
        ptts_ctl_t   ctl;
        logic [31:0] interval_ext, first_delay_ext;

        assign interval_ext    = {16'd0, interval_reg[i]};
        assign first_delay_ext = {16'd0, first_delay_reg[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                interval_reg[i]    <= INTERVAL_RESET[i];
                first_delay_reg[i] <= FIRST_DELAY_RESET[i];
            end else if (cfg_we) begin
                if (cfg_index == REG_INTERVAL_BASE + CFG_IDX_W'(i)) begin
                    interval_reg[i] <= cfg_data;
                end
                if (cfg_index == REG_FIRST_DELAY_BASE + CFG_IDX_W'(i)) begin
                    first_delay_reg[i] <= cfg_data;
                end
            end
        end

        always_comb begin
            ctl               = '0;
            ctl.enable_value  = s_data.enable_value;
            ctl.start_pending = s_data.start_pending_mask[i];
            if (accept) begin
                case (s_data.opcode)
                    OP_TICK:       ctl.tick = 1'b1;
                    OP_DISPATCH:   ctl.dispatch = 1'b1;
                    OP_SET_ENABLE: begin
                        ctl.set_enable = (s_data.task_index == TASK_IDX_W'(i));
                    end
                    OP_START:      ctl.start = 1'b1;
                    default:       ctl = ctl;
                endcase
            end
        end

        ptts_timer #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_timer (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (ctl),
            .interval     (interval_ext[COUNT_WIDTH-1:0]),
            .first_delay  (first_delay_ext[COUNT_WIDTH-1:0]),
            .dispatched   (disp_vec[i]),
            .pending_next (pend_vec[i]),
            .enabled_next (en_vec[i])
        );
    end

    always_comb begin
        result = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            result.dispatched_mask[i] = disp_vec[i];
            result.pending_mask[i]    = pend_vec[i];
            result.enable_mask[i]     = en_vec[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted word produced no result");

    a_dispatched_not_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.dispatched_mask & m_data.pending_mask) == '0))
        else $error("dispatched task still pending");

    a_dispatched_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.dispatched_mask & ~m_data.enable_mask) == '0))
        else $error("disabled task dispatched");

    a_dispatch_only_on_opcode: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.opcode != OP_DISPATCH)) |=> (m_data.dispatched_mask == '0))
        else $error("dispatch mask set by non-dispatch word");
`endif

endmodule
`default_nettype wire

[test/tb_periodic_task_tick_scheduler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler
// Drives tick, dispatch, set-enable and start words into the task timer bank
// and checks every status word against a scheduler model kept in the bench.
// Covers words just after reset, directed timer corner cases, randomized traffic over several
// interval and first-delay settings, and a long output stall.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;
    import ptts_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 10;
    localparam int PHASE_WORDS    = 125;
    localparam int MAX_REPORTS    = 10;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    ptts_in_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    ptts_out_t            m_data;

    // scheduler model state
    logic [CFG_W-1:0]  timing_regs [CFG_REGS];
    logic [CFG_W-1:0]  countdowns  [MAX_SLOTS];
    logic [MASK_W-1:0] pending_flags;
    logic [MASK_W-1:0] enable_flags;

    ptts_out_t status_q [$];
    ptts_out_t expected_status;
    int        err_count   = 0;
    int        idle_cycles = 0;
    bit        tx_smooth   = 1'b0;
    bit        rx_smooth   = 1'b0;
    bit        hold_start  = 1'b0;
    int        hold_left   = 0;
    int        stall_left  = 0;

    periodic_task_tick_scheduler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic ptts_out_t next_status(ptts_in_t w);
        ptts_out_t st;
        st.dispatched_mask = '0;
        case (op_t'(w.opcode))
            OP_TICK: begin
                for (int i = 0; i < MAX_SLOTS; i++) begin
                    if (enable_flags[i] && countdowns[i] != '0) begin
                        countdowns[i] = countdowns[i] - 1'b1;
                        if (countdowns[i] == '0) begin
                            countdowns[i]    = timing_regs[REG_INTERVAL_BASE + i];
                            pending_flags[i] = 1'b1;
                        end
                    end
                end
            end
            OP_DISPATCH: begin
                st.dispatched_mask = enable_flags & pending_flags;
                pending_flags      = pending_flags & ~enable_flags;
            end
            OP_SET_ENABLE: begin
                enable_flags[w.task_index] = w.enable_value;
            end
            OP_START: begin
                for (int i = 0; i < MAX_SLOTS; i++)
                    countdowns[i] = timing_regs[REG_FIRST_DELAY_BASE + i];
                pending_flags = w.start_pending_mask;
            end
            default: begin
            end
        endcase
        st.pending_mask = pending_flags;
        st.enable_mask  = enable_flags;
        return st;
    endfunction

    // model update, result check and watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                timing_regs[REG_INTERVAL_BASE + i]    = INTERVAL_RESET[i];
                timing_regs[REG_FIRST_DELAY_BASE + i] = FIRST_DELAY_RESET[i];
                countdowns[i]                         = '0;
            end
            pending_flags = '0;
            enable_flags  = '1;
            idle_cycles   = 0;
        end else begin
            if (cfg_we)
                timing_regs[cfg_index] = cfg_data;
            if (s_valid && s_ready)
                status_q.push_back(next_status(s_data));
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    if (err_count < MAX_REPORTS)
                        $display("unexpected status word: disp=%h pend=%h en=%h",
                                 m_data.dispatched_mask, m_data.pending_mask,
                                 m_data.enable_mask);
                    err_count++;
                end else begin
                    expected_status = status_q.pop_front();
                    if (expected_status.dispatched_mask !== m_data.dispatched_mask ||
                        expected_status.pending_mask !== m_data.pending_mask ||
                        expected_status.enable_mask !== m_data.enable_mask) begin
                        if (err_count < MAX_REPORTS)
                            $display({"status mismatch: expected disp=%h pend=%h en=%h,",
                                      " got disp=%h pend=%h en=%h"},
                                     expected_status.dispatched_mask,
                                     expected_status.pending_mask,
                                     expected_status.enable_mask,
                                     m_data.dispatched_mask, m_data.pending_mask,
                                     m_data.enable_mask);
                        err_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("tb_periodic_task_tick_scheduler: FAIL");
                $finish;
            end
        end
    end

    // result side ready, with random stalls and one long hold-off
    always @(negedge aclk) begin
        int r;
        if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (rx_smooth) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_ready <= 1'b1;
            end else if (r < 93) begin
                stall_left = $urandom_range(0, 2);
                m_ready    <= 1'b0;
            end else begin
                stall_left = $urandom_range(9, 59);
                m_ready    <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_smooth)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_W-1:0] pick_timing(int phase);
        int r;
        if (phase == 0)
            return 16'd1;
        if (phase == 1)
            return 16'hFFFF;
        if (phase == 2)
            return 16'd0;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'd0;
        if (r < 80)
            return CFG_W'($urandom_range(1, 6));
        if (r < 93)
            return CFG_W'($urandom_range(7, 40));
        return CFG_W'($urandom_range(0, 65535));
    endfunction

    function automatic ptts_in_t word_of(op_t op, int idx, bit en, int mask);
        ptts_in_t w;
        w.opcode             = op;
        w.task_index         = TASK_IDX_W'(idx);
        w.enable_value       = en;
        w.start_pending_mask = MASK_W'(mask);
        return w;
    endfunction

    function automatic ptts_in_t random_word();
        int r;
        ptts_in_t w;
        r = $urandom_range(0, 99);
        w = word_of(OP_TICK, $urandom_range(0, 3), $urandom_range(0, 3) != 0,
                    $urandom_range(0, 15));
        if (r < 55)
            w.opcode = OP_TICK;
        else if (r < 75)
            w.opcode = OP_DISPATCH;
        else if (r < 92)
            w.opcode = OP_SET_ENABLE;
        else
            w.opcode = OP_START;
        return w;
    endfunction

    task automatic send_word(input ptts_in_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic test_idle_after_reset();
        send_word(word_of(OP_TICK, 0, 1'b0, 0));
        send_word(word_of(OP_DISPATCH, 3, 1'b1, 15));
        wait_drained();
    endtask

    task automatic test_timer_corners();
        write_reg(REG_INTERVAL_BASE + 3'd0, 16'd1);
        write_reg(REG_INTERVAL_BASE + 3'd1, 16'd2);
        write_reg(REG_INTERVAL_BASE + 3'd2, 16'd0);
        write_reg(REG_INTERVAL_BASE + 3'd3, 16'hFFFF);
        write_reg(REG_FIRST_DELAY_BASE + 3'd0, 16'd1);
        write_reg(REG_FIRST_DELAY_BASE + 3'd1, 16'd0);
        write_reg(REG_FIRST_DELAY_BASE + 3'd2, 16'd3);
        write_reg(REG_FIRST_DELAY_BASE + 3'd3, 16'hFFFF);
        send_word(word_of(OP_START, 0, 1'b0, 4'b1010));
        send_word(word_of(OP_DISPATCH, 0, 1'b0, 0));
        repeat (4) send_word(word_of(OP_TICK, 0, 1'b0, 0));
        send_word(word_of(OP_SET_ENABLE, 0, 1'b0, 0));
        send_word(word_of(OP_TICK, 0, 1'b0, 0));
        send_word(word_of(OP_DISPATCH, 0, 1'b0, 0));
        for (int i = 1; i < MAX_SLOTS; i++)
            send_word(word_of(OP_SET_ENABLE, i, 1'b0, 15));
        send_word(word_of(OP_DISPATCH, 0, 1'b0, 0));
        for (int i = 0; i < MAX_SLOTS; i++)
            send_word(word_of(OP_SET_ENABLE, i, 1'b1, 0));
        send_word(word_of(OP_DISPATCH, 2, 1'b1, 15));
        send_word(word_of(OP_START, 3, 1'b1, 15));
        send_word(word_of(OP_START, 2, 1'b1, 0));
        wait_drained();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++) begin
            tx_smooth = (p == 4);
            rx_smooth = (p == 4);
            for (int j = 0; j < MAX_SLOTS; j++) begin
                write_reg(REG_INTERVAL_BASE + CFG_IDX_W'(j), pick_timing(p));
                write_reg(REG_FIRST_DELAY_BASE + CFG_IDX_W'(j), pick_timing(p));
            end
            send_word(word_of(OP_START, $urandom_range(0, 3), $urandom_range(0, 1) != 0,
                              $urandom_range(0, 15)));
            repeat (PHASE_WORDS) send_word(random_word());
            wait_drained();
        end
        tx_smooth = 1'b0;
        rx_smooth = 1'b0;
    endtask

    task automatic test_output_backpressure();
        @(posedge aclk);
        hold_start = 1'b1;
        tx_smooth  = 1'b1;
        repeat (60) send_word(random_word());
        tx_smooth = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_after_reset();
        test_timer_corners();
        test_random_phases();
        test_output_backpressure();
        repeat (4) @(posedge aclk);
        if (err_count == 0 && status_q.size() == 0)
            $display("tb_periodic_task_tick_scheduler: PASS");
        else
            $display("tb_periodic_task_tick_scheduler: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/ptts_pkg.sv
rtl/ptts_timer.sv
rtl/periodic_task_tick_scheduler.sv
test/tb_periodic_task_tick_scheduler.sv
